// File: rtl/mrrf_pkg.sv
// shared types and constants of the multi-reader ring fifo
package mrrf_pkg;

   // fixed field widths
   localparam int REQ_W         = 2;
   localparam int READER_W      = 2;
   localparam int STATUS_W      = 2;
   localparam int COUNT_W       = 32;
   localparam int USED_W        = 10;

   // configuration port
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 11;
   localparam int CFG_READERS_W = 3;
   localparam int CFG_DEPTH_W   = 11;

   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_READERS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEPTH_IN_USE   = 2'd1;

   localparam int CFG_READERS_RESET = 1;
   localparam int CFG_DEPTH_RESET   = 1024;

   // request codes on the input port
   localparam logic [REQ_W-1:0] REQ_PUSH    = 2'd0;
   localparam logic [REQ_W-1:0] REQ_PEEK    = 2'd1;
   localparam logic [REQ_W-1:0] REQ_ADVANCE = 2'd2;

   // status codes on the result port
   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_PUSH,
      OP_PEEK,
      OP_ADVANCE
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [READER_W-1:0] reader;
   } cmd_type;

   typedef enum logic [1:0] {
      BK_EXEC,
      BK_OCC,
      BK_EMIT
   } back_state_type;

endpackage

// File: rtl/mrrf_front.sv
// request intake: decodes the request type and folds the reader index
module mrrf_front #(
   parameter int MAX_READERS = 4
) (
   input  logic                           start,
   input  logic [mrrf_pkg::REQ_W-1:0]     req_type,
   input  logic [mrrf_pkg::READER_W-1:0]  req_reader_index,
   input  logic                           q_full,
   output logic                           busy,
   output logic                           q_push,
   output mrrf_pkg::cmd_type              q_cmd
);
   import mrrf_pkg::*;

   // reader index modulo the reader count, by repeated subtract on a 2-bit value
   function automatic logic [READER_W-1:0] wrap_reader(input logic [READER_W-1:0] idx);
      logic [READER_W-1:0] v;
      v = idx;
      for (int k = 0; k < (1 << READER_W); k++) begin
         if (32'(v) >= 32'(MAX_READERS)) begin
            v = v - READER_W'(MAX_READERS);
         end
      end
      return v;
   endfunction

   always_comb begin
      q_cmd.reader = wrap_reader(req_reader_index);
      case (req_type)
         REQ_PUSH:    q_cmd.op = OP_PUSH;
         REQ_PEEK:    q_cmd.op = OP_PEEK;
         REQ_ADVANCE: q_cmd.op = OP_ADVANCE;
         default:     q_cmd.op = OP_NONE;
      endcase
   end

   assign busy   = q_full;
   assign q_push = start && !q_full;

endmodule

// File: rtl/mrrf_cmd_queue.sv
// two-entry command queue between intake and execution
module mrrf_cmd_queue #(
   parameter int WORD_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  mrrf_pkg::cmd_type    push_cmd,
   input  logic [WORD_BITS-1:0] push_data,
   input  logic                 pop,
   output logic                 full,
   output logic                 valid,
   output mrrf_pkg::cmd_type    head_cmd,
   output logic [WORD_BITS-1:0] head_data
);
   import mrrf_pkg::*;

   cmd_type              cmd_mem  [QUEUE_DEPTH];
   logic [WORD_BITS-1:0] data_mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]    count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         cmd_mem[wr_ptr_ff]  <= push_cmd;
         data_mem[wr_ptr_ff] <= push_data;
      end
   end

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign valid     = (count_ff != '0);
   assign head_cmd  = cmd_mem[rd_ptr_ff];
   assign head_data = data_mem[rd_ptr_ff];

endmodule

// File: rtl/mrrf_back.sv
// execution: ring store, head and reader tails, occupancy and result registers
module mrrf_back #(
   parameter int DEPTH       = 1024,
   parameter int WORD_BITS   = 32,
   parameter int MAX_READERS = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [mrrf_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [mrrf_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                              q_valid,
   input  mrrf_pkg::cmd_type                 q_cmd,
   input  logic [WORD_BITS-1:0]              q_data,
   output logic                              q_pop,
   output logic                              rsp_strobe,
   output logic [WORD_BITS-1:0]              rsp_read_data,
   output logic [mrrf_pkg::STATUS_W-1:0]     rsp_status,
   output logic                              rsp_full_flag,
   output logic [mrrf_pkg::COUNT_W-1:0]      rsp_overrun_count,
   output logic [mrrf_pkg::USED_W-1:0]       rsp_used_elements
);
   import mrrf_pkg::*;

   localparam int PTR_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int DW          = PTR_W + 1;
   localparam int RI_W        = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1;
   localparam int RN_W        = $clog2(MAX_READERS + 1);
   localparam int DEPTH_RESET = (CFG_DEPTH_RESET > DEPTH) ? DEPTH : CFG_DEPTH_RESET;

   back_state_type       state_ff, state_in;
   logic                 exec_en, occ_en, emit_en;

   logic [RN_W-1:0]      nr_ff, nr_in;
   logic [DW-1:0]        d_ff, d_in;
   logic [CFG_READERS_W-1:0] readers_wr;
   logic [CFG_DEPTH_W-1:0]   depth_wr;

   logic [PTR_W-1:0]     head_ff, head_in;
   logic [PTR_W-1:0]     tail_ff [MAX_READERS];
   logic [PTR_W-1:0]     tail_in [MAX_READERS];
   logic                 full_ff, full_in;
   logic [COUNT_W-1:0]   ovr_ff, ovr_in;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic                 rd_ok_ff, rd_ok_in;

   logic [RI_W-1:0]      rd_idx;
   logic [PTR_W-1:0]     dm1, head_next, cur_tail, tail_next;
   logic                 blocked, tail_empty;
   logic                 ring_we, ring_re;

   logic [WORD_BITS-1:0] ring_mem [DEPTH];
   logic [WORD_BITS-1:0] ring_rdata_ff;
   logic [PTR_W-1:0]     occ_ff [MAX_READERS];
   logic [PTR_W-1:0]     used_max;

   logic                 rsp_strobe_ff;
   logic [WORD_BITS-1:0] rsp_read_data_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic                 rsp_full_flag_ff;
   logic [COUNT_W-1:0]   rsp_overrun_count_ff;
   logic [USED_W-1:0]    rsp_used_elements_ff;

   // elements between tail and head, capped at d-1; zero when the tail lies more than d past the head
   function automatic logic [PTR_W-1:0] occupancy(input logic [PTR_W-1:0] head,
                                                  input logic [PTR_W-1:0] tail,
                                                  input logic [DW-1:0]    d);
      logic [DW-1:0] u;
      logic [DW-1:0] gap;
      gap = DW'(tail) - DW'(head);
      if (head >= tail) begin
         u = DW'(head) - DW'(tail);
      end else if (gap <= d) begin
         u = d - gap;
      end else begin
         u = '0;
      end
      if (u > d - DW'(1)) begin
         u = d - DW'(1);
      end
      return PTR_W'(u);
   endfunction

   // sequencer: execute, take occupancy, register the result
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_EXEC: if (q_valid) begin
            state_in = BK_OCC;
         end
         BK_OCC:  state_in = BK_EMIT;
         BK_EMIT: state_in = BK_EXEC;
         default: state_in = BK_EXEC;
      endcase
   end

   always_comb begin
      exec_en = 1'b0;
      occ_en  = 1'b0;
      emit_en = 1'b0;
      case (state_ff)
         BK_EXEC: exec_en = q_valid;
         BK_OCC:  occ_en  = 1'b1;
         BK_EMIT: emit_en = 1'b1;
         default: ;
      endcase
   end

   assign q_pop = exec_en;

   // configuration, saturated on write
   always_comb begin
      readers_wr = csr_wdata[CFG_READERS_W-1:0];
      depth_wr   = csr_wdata[CFG_DEPTH_W-1:0];
      nr_in      = nr_ff;
      d_in       = d_ff;
      if (csr_we && csr_index == CSR_ACTIVE_READERS) begin
         if (readers_wr == '0) begin
            nr_in = RN_W'(1);
         end else if (32'(readers_wr) > 32'(MAX_READERS)) begin
            nr_in = RN_W'(MAX_READERS);
         end else begin
            nr_in = RN_W'(readers_wr);
         end
      end
      if (csr_we && csr_index == CSR_DEPTH_IN_USE) begin
         if (32'(depth_wr) < 32'd2) begin
            d_in = DW'(2);
         end else if (32'(depth_wr) > 32'(DEPTH)) begin
            d_in = DW'(DEPTH);
         end else begin
            d_in = DW'(depth_wr);
         end
      end
   end

   // request execution
   always_comb begin
      rd_idx     = RI_W'(q_cmd.reader);
      dm1        = PTR_W'(d_ff - DW'(1));
      head_next  = (head_ff >= dm1) ? '0 : head_ff + PTR_W'(1);
      cur_tail   = tail_ff[rd_idx];
      tail_next  = (cur_tail >= dm1) ? '0 : cur_tail + PTR_W'(1);
      tail_empty = (cur_tail == head_ff);
      blocked    = 1'b0;
      for (int i = 0; i < MAX_READERS; i++) begin
         if (32'(i) < 32'(nr_ff) && tail_ff[i] == head_next) begin
            blocked = 1'b1;
         end
      end

      head_in   = head_ff;
      tail_in   = tail_ff;
      full_in   = full_ff;
      ovr_in    = ovr_ff;
      status_in = status_ff;
      rd_ok_in  = rd_ok_ff;
      ring_we   = 1'b0;
      ring_re   = 1'b0;
      if (exec_en) begin
         status_in = ST_DONE;
         rd_ok_in  = 1'b0;
         case (q_cmd.op)
            OP_PUSH: begin
               if (blocked) begin
                  full_in   = 1'b1;
                  ovr_in    = ovr_ff + COUNT_W'(1);
                  status_in = ST_FULL;
               end else begin
                  ring_we = 1'b1;
                  head_in = head_next;
                  full_in = 1'b0;
               end
            end
            OP_PEEK, OP_ADVANCE: begin
               if (tail_empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  ring_re  = 1'b1;
                  rd_ok_in = 1'b1;
                  if (q_cmd.op == OP_ADVANCE) begin
                     tail_in[rd_idx] = tail_next;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_EXEC;
         nr_ff         <= RN_W'(CFG_READERS_RESET);
         d_ff          <= DW'(DEPTH_RESET);
         head_ff       <= '0;
         full_ff       <= 1'b0;
         ovr_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
         for (int i = 0; i < MAX_READERS; i++) begin
            tail_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         nr_ff         <= nr_in;
         d_ff          <= d_in;
         head_ff       <= head_in;
         full_ff       <= full_in;
         ovr_ff        <= ovr_in;
         rsp_strobe_ff <= emit_en;
         tail_ff       <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      rd_ok_ff  <= rd_ok_in;
   end

   // ring store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[head_ff] <= q_data;
      end
      if (ring_re) begin
         ring_rdata_ff <= ring_mem[cur_tail];
      end
   end

   // per-reader occupancy after the request, inactive readers count as zero
   always_ff @(posedge clock) begin
      if (occ_en) begin
         for (int i = 0; i < MAX_READERS; i++) begin
            occ_ff[i] <= (32'(i) < 32'(nr_ff)) ? occupancy(head_ff, tail_ff[i], d_ff) : '0;
         end
      end
   end

   always_comb begin
      used_max = '0;
      for (int i = 0; i < MAX_READERS; i++) begin
         if (occ_ff[i] > used_max) begin
            used_max = occ_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit_en) begin
         rsp_read_data_ff     <= rd_ok_ff ? ring_rdata_ff : '0;
         rsp_status_ff        <= status_ff;
         rsp_full_flag_ff     <= full_ff;
         rsp_overrun_count_ff <= ovr_ff;
         rsp_used_elements_ff <= USED_W'(used_max);
      end
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_read_data     = rsp_read_data_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_full_flag     = rsp_full_flag_ff;
   assign rsp_overrun_count = rsp_overrun_count_ff;
   assign rsp_used_elements = rsp_used_elements_ff;

   a_strobe_after_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(state_ff) == BK_EMIT)
      else $error("result strobe without a preceding emit step");

   a_push_moves_head: assert property (@(posedge clock) disable iff (reset)
      ring_we |=> head_ff != $past(head_ff))
      else $error("ring written but head did not move");

   a_overrun_only_on_push: assert property (@(posedge clock) disable iff (reset)
      exec_en && q_cmd.op != OP_PUSH |=> ovr_ff == $past(ovr_ff))
      else $error("overrun count changed on a non-push request");

   a_full_status_sets_flag: assert property (@(posedge clock) disable iff (reset)
      emit_en && status_ff == ST_FULL |-> full_ff)
      else $error("refused push reported without the full flag");

endmodule

// File: rtl/multi_reader_ring_fifo_core.sv
// top level of the multi-reader ring fifo
// One writer pushes words into a ring and up to MAX_READERS readers each
// peek or advance their own tail. A request is taken when start is high and
// busy is low; a two-entry command queue sits in front of the execution
// sequencer, so start may be raised again right away until that queue fills.
// Execution runs three steps per request (execute with the ring write or
// read, occupancy per reader, result register), and the sequencer takes the
// next request from the queue only after the last step of the previous one.
// A result appears with rsp_strobe high for one cycle, in request order,
// after the command queue and the three steps; the receiver cannot stall
// it and must take it in that cycle. Configuration must be written through
// csr_we/csr_index/csr_wdata only while no request is pending or in flight;
// the block does not enforce this; values outside the legal range are saturated.
module multi_reader_ring_fifo_core #(
   parameter int DEPTH       = 1024,
   parameter int WORD_BITS   = 32,
   parameter int MAX_READERS = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [mrrf_pkg::REQ_W-1:0]        req_type,
   input  logic [mrrf_pkg::READER_W-1:0]     req_reader_index,
   input  logic [WORD_BITS-1:0]              req_push_data,
   output logic                              rsp_strobe,
   output logic [WORD_BITS-1:0]              rsp_read_data,
   output logic [mrrf_pkg::STATUS_W-1:0]     rsp_status,
   output logic                              rsp_full_flag,
   output logic [mrrf_pkg::COUNT_W-1:0]      rsp_overrun_count,
   output logic [mrrf_pkg::USED_W-1:0]       rsp_used_elements,
   input  logic                              csr_we,
   input  logic [mrrf_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [mrrf_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import mrrf_pkg::*;

   logic                 q_full, q_push, q_valid, q_pop;
   cmd_type              push_cmd, head_cmd;
   logic [WORD_BITS-1:0] head_data;

   mrrf_front #(
      .MAX_READERS(MAX_READERS)
   ) u_front (
      .start            (start),
      .req_type         (req_type),
      .req_reader_index (req_reader_index),
      .q_full           (q_full),
      .busy             (busy),
      .q_push           (q_push),
      .q_cmd            (push_cmd)
   );

   mrrf_cmd_queue #(
      .WORD_BITS(WORD_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (push_cmd),
      .push_data (req_push_data),
      .pop       (q_pop),
      .full      (q_full),
      .valid     (q_valid),
      .head_cmd  (head_cmd),
      .head_data (head_data)
   );

   mrrf_back #(
      .DEPTH      (DEPTH),
      .WORD_BITS  (WORD_BITS),
      .MAX_READERS(MAX_READERS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .q_valid           (q_valid),
      .q_cmd             (head_cmd),
      .q_data            (head_data),
      .q_pop             (q_pop),
      .rsp_strobe        (rsp_strobe),
      .rsp_read_data     (rsp_read_data),
      .rsp_status        (rsp_status),
      .rsp_full_flag     (rsp_full_flag),
      .rsp_overrun_count (rsp_overrun_count),
      .rsp_used_elements (rsp_used_elements)
   );

endmodule
